### rtl/swrr_pkg.sv
// ----------------------------------------------------------------------------
// swrr_pkg
// shared types and constants of the smooth weighted round-robin selector
// ----------------------------------------------------------------------------
package swrr_pkg;

	// fixed field and register widths
	localparam int SLOT_W   = 3;
	localparam int TABLE_W  = 64;
	localparam int COUNT_W  = 4;
	localparam int HEALTH_W = 8;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 64;

	// current weight range and working width of the add and subtract
	localparam int CW_W   = 13;
	localparam int SUM_W  = 15;
	localparam int CW_MAX = 4095;
	localparam int CW_MIN = -4095;

	// register reset values
	localparam logic [TABLE_W-1:0]  WEIGHTS_RST = 64'h0101_0101_0101_0101;
	localparam logic [COUNT_W-1:0]  SLOTS_RST   = 4'd0;
	localparam logic [HEALTH_W-1:0] HEALTH_RST  = 8'hFF;

	// register indexes (byte address 8*index)
	localparam logic [1:0] REG_WEIGHTS = 2'd0;
	localparam logic [1:0] REG_SLOTS   = 2'd1;
	localparam logic [1:0] REG_HEALTH  = 2'd2;

	// request commands
	localparam logic CMD_SELECT = 1'b0;
	localparam logic CMD_MARK   = 1'b1;

	typedef enum logic [1:0] {
		ST_SELECTED   = 2'd0,
		ST_NO_SLOTS   = 2'd1,
		ST_NO_HEALTHY = 2'd2,
		ST_MARKED     = 2'd3
	} status_t;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] slot;
		logic              healthy;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] chosen_slot;
		status_t           status;
	} rsp_t;

	typedef struct packed {
		logic [TABLE_W-1:0]  weight_table;
		logic [COUNT_W-1:0]  slots_in_use;
		logic [HEALTH_W-1:0] initial_health;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic    latch;
		logic    mark;
		logic    start;
		logic    step;
		logic    apply;
		logic    load;
		status_t status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_mark;
		logic no_slots;
		logic last;
		logic found;
	} sts_t;

endpackage

### rtl/smooth_weighted_round_robin.sv
// ----------------------------------------------------------------------------
// smooth_weighted_round_robin
// smooth weighted round-robin selector over up to eight weighted slots
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req       in         req_valid / req_stall   swrr_pkg::req_t
//  rsp       out        rsp_valid / rsp_stall   swrr_pkg::rsp_t
//  apb       in         psel / penable / pready 64-bit registers at 8*index
//
//  one request at a time; a mark or an empty configuration skips the scan,
//  a select scans the n slots in use (one slot per cycle through the shared
//  add and compare). the next request is taken while a finished response
//  waits on rsp_stall. reset clears all current weights and marks every
//  slot healthy; each register write does the same in the following cycle,
//  with the stored health mask.
// ----------------------------------------------------------------------------
module smooth_weighted_round_robin #(
	parameter int NUM_SLOTS   = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  swrr_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output swrr_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swrr_pkg::ADDR_W-1:0] paddr,
	input  logic [swrr_pkg::DATA_W-1:0] pwdata,
	output logic [swrr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	swrr_pkg::cfg_t cfg;
	swrr_pkg::cmd_t cmd;
	swrr_pkg::sts_t sts;
	logic           reload;

	// configuration registers
	swrr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.reload  (reload)
	);

	// sequencer
	swrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot state and search
	swrr_dpath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.reload (reload),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	// a taken request blocks the next one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while another is in work");

	// only a selection carries a slot number
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != swrr_pkg::ST_SELECTED) |-> (rsp.chosen_slot == '0))
		else $error("non-zero slot on a response that is not a selection");

	// a chosen slot is one that exists
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == swrr_pkg::ST_SELECTED)
			|-> ({1'b0, rsp.chosen_slot} < 4'(NUM_SLOTS)))
		else $error("chosen slot beyond the slots built");
`endif

endmodule

### rtl/swrr_regs.sv
// ----------------------------------------------------------------------------
// swrr_regs
// apb configuration registers with a reload pulse after every write to a known register
// ----------------------------------------------------------------------------
module swrr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swrr_pkg::ADDR_W-1:0]   paddr,
	input  logic [swrr_pkg::DATA_W-1:0]   pwdata,
	output logic [swrr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output swrr_pkg::cfg_t                cfg,
	output logic                          reload
);

	localparam int ADDR_LO = 3;
	localparam int ADDR_HI = swrr_pkg::ADDR_W - 1;

	swrr_pkg::cfg_t cfg_q;
	logic           reload_q;
	logic           wr_en;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_HI:ADDR_LO];
	assign wr_en   = psel & penable & pwrite;

	// register writes, any write to a known register reloads the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_table   <= swrr_pkg::WEIGHTS_RST;
			cfg_q.slots_in_use   <= swrr_pkg::SLOTS_RST;
			cfg_q.initial_health <= swrr_pkg::HEALTH_RST;
			reload_q             <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (wr_en) begin
				case (reg_idx)
					swrr_pkg::REG_WEIGHTS: begin
						cfg_q.weight_table <= pwdata[swrr_pkg::TABLE_W-1:0];
						reload_q           <= 1'b1;
					end
					swrr_pkg::REG_SLOTS: begin
						cfg_q.slots_in_use <= pwdata[swrr_pkg::COUNT_W-1:0];
						reload_q           <= 1'b1;
					end
					swrr_pkg::REG_HEALTH: begin
						cfg_q.initial_health <= pwdata[swrr_pkg::HEALTH_W-1:0];
						reload_q             <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			swrr_pkg::REG_WEIGHTS: prdata = cfg_q.weight_table;
			swrr_pkg::REG_SLOTS:
				prdata = {{(swrr_pkg::DATA_W-swrr_pkg::COUNT_W){1'b0}}, cfg_q.slots_in_use};
			swrr_pkg::REG_HEALTH:
				prdata = {{(swrr_pkg::DATA_W-swrr_pkg::HEALTH_W){1'b0}}, cfg_q.initial_health};
			default: prdata = '0;
		endcase
	end

	assign cfg    = cfg_q;
	assign reload = reload_q;

endmodule

### rtl/swrr_ctrl.sv
// ----------------------------------------------------------------------------
// swrr_ctrl
// sequencer: takes a request, steps the slot scan and hands off the result
// ----------------------------------------------------------------------------
module swrr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  swrr_pkg::sts_t sts,
	output swrr_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_APPLY  = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	swrr_pkg::status_t status_q, status_d;
	logic              rsp_valid_q;
	logic              out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		cmd        = '0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_mark) begin
					cmd.mark = 1'b1;
					status_d = swrr_pkg::ST_MARKED;
					state_d  = S_RESULT;
				end else if (sts.no_slots) begin
					status_d = swrr_pkg::ST_NO_SLOTS;
					state_d  = S_RESULT;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				if (sts.found) begin
					cmd.apply = 1'b1;
					status_d  = swrr_pkg::ST_SELECTED;
				end else begin
					status_d = swrr_pkg::ST_NO_HEALTHY;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, pending status and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= swrr_pkg::ST_SELECTED;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/swrr_dpath.sv
// ----------------------------------------------------------------------------
// swrr_dpath
// slot state, one-slot-per-cycle weight update and best search, result register
// ----------------------------------------------------------------------------
module swrr_dpath #(
	parameter int NUM_SLOTS   = 8,
	parameter int WEIGHT_BITS = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  swrr_pkg::cfg_t cfg,
	input  logic           reload,
	input  swrr_pkg::req_t req,
	input  swrr_pkg::cmd_t cmd,
	output swrr_pkg::sts_t sts,
	output swrr_pkg::rsp_t rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam int TOT_W = WEIGHT_BITS + CNT_W;
	localparam int SUM_W = swrr_pkg::SUM_W;
	localparam int CW_W  = swrr_pkg::CW_W;

	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(swrr_pkg::CW_MAX);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(swrr_pkg::CW_MIN);

	swrr_pkg::req_t                req_q;
	swrr_pkg::rsp_t                rsp_q;
	logic signed [CW_W-1:0]        cw_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]          health_q;
	logic [WEIGHT_BITS-1:0]        weight [NUM_SLOTS];
	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              best_q;
	logic signed [CW_W-1:0]        best_val_q;
	logic                          found_q;
	logic [TOT_W-1:0]              total_q;

	logic [swrr_pkg::COUNT_W-1:0]  n_full;
	logic [CNT_W-1:0]              n_act;
	logic                          mark_ok;
	logic signed [SUM_W-1:0]       add_sum;
	logic signed [CW_W-1:0]        add_sat;
	logic signed [SUM_W-1:0]       sub_sum;
	logic signed [CW_W-1:0]        sub_sat;
	logic                          take;

	// per-slot weights taken from the table
	for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_weight
		assign weight[k] = cfg.weight_table[k*swrr_pkg::BYTE_W +: WEIGHT_BITS];
	end

	// slots in use, limited to the slots built
	assign n_full = (cfg.slots_in_use > swrr_pkg::COUNT_W'(NUM_SLOTS)) ?
		swrr_pkg::COUNT_W'(NUM_SLOTS) : cfg.slots_in_use;
	assign n_act   = n_full[CNT_W-1:0];
	assign mark_ok = ({1'b0, req_q.slot} < n_full);

	// add the slot weight and clamp from above
	assign add_sum = SUM_W'(cw_q[idx_q]) + $signed({{(SUM_W-WEIGHT_BITS){1'b0}}, weight[idx_q]});
	assign add_sat = (add_sum > SAT_HI) ? CW_W'(SAT_HI) : add_sum[CW_W-1:0];
	assign take    = health_q[idx_q] && (!found_q || (add_sat > best_val_q));

	// subtract the total from the winner and clamp from below
	assign sub_sum = SUM_W'(best_val_q) - $signed({{(SUM_W-TOT_W){1'b0}}, total_q});
	assign sub_sat = (sub_sum < SAT_LO) ? CW_W'(SAT_LO) : sub_sum[CW_W-1:0];

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
	end

	// current weights and health flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				cw_q[k] <= '0;
			end
			health_q <= '1;
		end else if (reload) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				cw_q[k] <= '0;
			end
			health_q <= cfg.initial_health[NUM_SLOTS-1:0];
		end else begin
			if (cmd.mark && mark_ok) begin
				health_q[req_q.slot[IDX_W-1:0]] <= req_q.healthy;
			end
			if (cmd.step && health_q[idx_q]) begin
				cw_q[idx_q] <= add_sat;
			end
			if (cmd.apply) begin
				cw_q[best_q] <= sub_sat;
			end
		end
	end

	// scan index, running total and best so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + IDX_W'(1);
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			total_q <= '0;
		end else if (cmd.step) begin
			if (health_q[idx_q]) begin
				total_q <= total_q + TOT_W'(weight[idx_q]);
			end
			if (take) begin
				best_q     <= idx_q;
				best_val_q <= add_sat;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status <= cmd.status;
			rsp_q.chosen_slot <= (cmd.status == swrr_pkg::ST_SELECTED) ?
				swrr_pkg::SLOT_W'(best_q) : '0;
		end
	end

	assign sts.is_mark  = (req_q.command == swrr_pkg::CMD_MARK);
	assign sts.no_slots = (n_act == '0);
	assign sts.last     = ((CNT_W'(idx_q) + CNT_W'(1)) == n_act);
	assign sts.found    = found_q;
	assign rsp          = rsp_q;

endmodule

### verif/tb_smooth_weighted_round_robin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smooth_weighted_round_robin
// self-checking bench for the smooth weighted round-robin selector
// ----------------------------------------------------------------------------
//  a queue of pending requests feeds a clocked driver; each request is
//  predicted when it is accepted, and a clocked monitor compares every
//  response against the oldest prediction. registers are written over apb
//  only while the selector is idle. a short directed run covers the corner
//  cases, then random phases vary weights, slot count, health masks and
//  the idling on both channels.
// ----------------------------------------------------------------------------
module tb_smooth_weighted_round_robin;

	localparam int NUM_SLOTS      = 8;
	localparam int WEIGHT_BITS    = 8;
	localparam int RANDOM_ITEMS   = 1350;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 1000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          req_valid = 1'b0;
	logic                          req_stall;
	swrr_pkg::req_t                req       = '0;
	logic                          rsp_valid;
	logic                          rsp_stall = 1'b0;
	swrr_pkg::rsp_t                rsp;
	logic                          psel      = 1'b0;
	logic                          penable   = 1'b0;
	logic                          pwrite    = 1'b0;
	logic [swrr_pkg::ADDR_W-1:0]   paddr     = '0;
	logic [swrr_pkg::DATA_W-1:0]   pwdata    = '0;
	logic [swrr_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	// mirrored registers and selector state
	logic [swrr_pkg::TABLE_W-1:0]  cfg_table  = swrr_pkg::WEIGHTS_RST;
	logic [swrr_pkg::COUNT_W-1:0]  cfg_count  = swrr_pkg::SLOTS_RST;
	logic [swrr_pkg::HEALTH_W-1:0] cfg_health = swrr_pkg::HEALTH_RST;
	logic signed [swrr_pkg::CW_W-1:0] cur_weight [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]          slot_ok;

	swrr_pkg::req_t request_backlog [$];
	swrr_pkg::rsp_t awaited_picks   [$];

	int             mismatches   = 0;
	int             gap_left     = 0;
	int             stall_left   = 0;
	int             stall_draw   = 0;
	int             quiet_cycles = 0;
	bit             calm         = 1'b0;
	swrr_pkg::rsp_t want;

	smooth_weighted_round_robin #(
		.NUM_SLOTS   (NUM_SLOTS),
		.WEIGHT_BITS (WEIGHT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// clear current weights and reload health flags after any register write
	function automatic void reload_mirror();
		for (int k = 0; k < NUM_SLOTS; k++) begin
			cur_weight[k] = '0;
			slot_ok[k]    = cfg_health[k];
		end
	endfunction

	// next pick of the selector for one request, updating the mirrored state
	function automatic swrr_pkg::rsp_t predict_pick(swrr_pkg::req_t r);
		swrr_pkg::rsp_t o;
		int             n;
		int             total;
		int             best;
		int             best_val;
		int             w;
		int             acc;
		o.chosen_slot = '0;
		o.status      = swrr_pkg::ST_MARKED;
		n = (int'(cfg_count) > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_count);
		if (r.command == swrr_pkg::CMD_MARK) begin
			if (int'(r.slot) < n)
				slot_ok[r.slot] = r.healthy;
			return o;
		end
		if (n == 0) begin
			o.status = swrr_pkg::ST_NO_SLOTS;
			return o;
		end
		total    = 0;
		best     = -1;
		best_val = 0;
		// add weights of healthy slots, remember first largest
		for (int k = 0; k < n; k++) begin
			if (slot_ok[k]) begin
				w   = int'(cfg_table[8*k +: 8]) & ((1 << WEIGHT_BITS) - 1);
				acc = int'(cur_weight[k]) + w;
				if (acc > swrr_pkg::CW_MAX)
					acc = swrr_pkg::CW_MAX;
				cur_weight[k] = swrr_pkg::CW_W'(acc);
				total += w;
				if (best < 0 || acc > best_val) begin
					best_val = acc;
					best     = k;
				end
			end
		end
		if (best < 0) begin
			o.status = swrr_pkg::ST_NO_HEALTHY;
			return o;
		end
		// charge the winner with the healthy weight sum
		acc = int'(cur_weight[best]) - total;
		if (acc < swrr_pkg::CW_MIN)
			acc = swrr_pkg::CW_MIN;
		cur_weight[best] = swrr_pkg::CW_W'(acc);
		o.chosen_slot    = best[swrr_pkg::SLOT_W-1:0];
		o.status         = swrr_pkg::ST_SELECTED;
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
			gap_left  <= 0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid)
				awaited_picks = {awaited_picks, predict_pick(req)};
			if (gap_left > 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (request_backlog.size() != 0) begin
				req       <= request_backlog.pop_front();
				req_valid <= 1'b1;
				gap_left  <= idle_length();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (awaited_picks.size() == 0) begin
					mismatches++;
					$display("%0t: response with none awaited, got slot %0d status %0d",
						$time, rsp.chosen_slot, rsp.status);
				end else begin
					want = awaited_picks.pop_front();
					if (rsp.chosen_slot !== want.chosen_slot || rsp.status !== want.status) begin
						mismatches++;
						$display("%0t: response mismatch, expected slot %0d status %s, %s",
							$time, want.chosen_slot, want.status.name(),
							$sformatf("got slot %0d status %0d",
								rsp.chosen_slot, rsp.status));
					end
				end
			end
			if (stall_left > 0) begin
				rsp_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				stall_draw = idle_length();
				rsp_stall  <= (stall_draw != 0);
				stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_smooth_weighted_round_robin: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// apb write: setup then access, mirror updated on completion
	task automatic set_register(input logic [1:0] idx,
		input logic [swrr_pkg::TABLE_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			swrr_pkg::REG_WEIGHTS: cfg_table  = value;
			swrr_pkg::REG_SLOTS:   cfg_count  = value[swrr_pkg::COUNT_W-1:0];
			swrr_pkg::REG_HEALTH:  cfg_health = value[swrr_pkg::HEALTH_W-1:0];
			default: ;
		endcase
		reload_mirror();
		@(negedge clk);
	endtask

	task automatic queue_request(input logic cmd, input int slot, input logic flag);
		swrr_pkg::req_t r;
		r.command = cmd;
		r.slot    = slot[swrr_pkg::SLOT_W-1:0];
		r.healthy = flag;
		request_backlog = {request_backlog, r};
	endtask

	// wait for every request answered, then let the selector settle
	task automatic wait_idle();
		do @(negedge clk);
		while (request_backlog.size() != 0 || req_valid || awaited_picks.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// stimulus
	initial begin
		int                            random_sent;
		int                            phase_items;
		int                            roll;
		int                            mark_pct;
		logic [2:0]                    which;
		logic [swrr_pkg::TABLE_W-1:0]  table_val;
		logic [7:0]                    byte_val;
		random_sent = 0;
		reload_mirror();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: no slots in use
		queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		queue_request(swrr_pkg::CMD_MARK, 0, 1'b0);
		queue_request(swrr_pkg::CMD_MARK, 7, 1'b1);
		wait_idle();

		// full weights on all eight slots, one slot dropped and restored
		set_register(swrr_pkg::REG_WEIGHTS, '1);
		set_register(swrr_pkg::REG_SLOTS, 64'd8);
		set_register(swrr_pkg::REG_HEALTH, 64'hFF);
		repeat (3) queue_request(swrr_pkg::CMD_SELECT, 7, 1'b1);
		queue_request(swrr_pkg::CMD_MARK, 7, 1'b0);
		queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		queue_request(swrr_pkg::CMD_MARK, 7, 1'b1);
		wait_idle();

		// all weights zero: first healthy slot wins, nothing moves
		set_register(swrr_pkg::REG_WEIGHTS, '0);
		set_register(swrr_pkg::REG_HEALTH, 64'h5A);
		repeat (2) queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		wait_idle();

		// slot count above the maximum, no slot healthy until one is marked
		set_register(swrr_pkg::REG_HEALTH, 64'h00);
		set_register(swrr_pkg::REG_SLOTS, 64'd15);
		queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		queue_request(swrr_pkg::CMD_MARK, 3, 1'b1);
		queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		wait_idle();

		// mixed weights on three slots, marks outside the slots in use
		set_register(swrr_pkg::REG_WEIGHTS, 64'h0000_0000_00FF_0102);
		set_register(swrr_pkg::REG_SLOTS, 64'd3);
		queue_request(swrr_pkg::CMD_MARK, 5, 1'b0);
		repeat (3) queue_request(swrr_pkg::CMD_SELECT, 2, 1'b1);
		wait_idle();
		set_register(swrr_pkg::REG_HEALTH, 64'hF8);
		queue_request(swrr_pkg::CMD_SELECT, 0, 1'b0);
		wait_idle();

		// random phases
		while (random_sent < RANDOM_ITEMS) begin
			calm  = ($urandom_range(0, 3) == 0);
			which = 3'($urandom_range(1, 7));
			if (which[0]) begin
				for (int b = 0; b < 8; b++) begin
					case ($urandom_range(0, 9))
						0:       byte_val = 8'h00;
						1:       byte_val = 8'hFF;
						2:       byte_val = 8'($urandom_range(1, 3));
						default: byte_val = 8'($urandom_range(0, 255));
					endcase
					table_val[8*b +: 8] = byte_val;
				end
				set_register(swrr_pkg::REG_WEIGHTS, table_val);
			end
			if (which[1]) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					set_register(swrr_pkg::REG_SLOTS, 64'd0);
				else if (roll == 1)
					set_register(swrr_pkg::REG_SLOTS, 64'($urandom_range(9, 15)));
				else
					set_register(swrr_pkg::REG_SLOTS, 64'($urandom_range(1, 8)));
			end
			if (which[2])
				set_register(swrr_pkg::REG_HEALTH,
					64'(($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 255)));

			// some phases churn health flags hard
			mark_pct    = ($urandom_range(0, 3) == 0) ? 40 : 15;
			phase_items = $urandom_range(60, 140);
			for (int i = 0; i < phase_items; i++) begin
				if ($urandom_range(0, 99) < mark_pct)
					queue_request(swrr_pkg::CMD_MARK, $urandom_range(0, 7),
						$urandom_range(0, 99) < 65);
				else
					queue_request(swrr_pkg::CMD_SELECT, $urandom_range(0, 7),
						1'($urandom_range(0, 1)));
			end
			random_sent += phase_items;
			wait_idle();
		end

		if (mismatches == 0)
			$display("tb_smooth_weighted_round_robin: PASS");
		else
			$display("tb_smooth_weighted_round_robin: FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/swrr_pkg.sv
rtl/swrr_regs.sv
rtl/swrr_ctrl.sv
rtl/swrr_dpath.sv
rtl/smooth_weighted_round_robin.sv
verif/tb_smooth_weighted_round_robin.sv
